[design/sfi_pkg.sv]
// Shared types and constants for the sorted key find-or-insert block.
// No dependencies.
`default_nettype none

package sfi_pkg;

	localparam int KEY_W    = 16;
	localparam int HANDLE_W = 6;

	// token that walks the cell chain, one cell per cycle unless the chain is stalled
	typedef struct packed {
		logic                       act;        // token present
		logic                       has_entry;  // still carrying an entry to place
		logic                       nins;       // table full at entry: lookup only
		logic                       hit;        // key found
		logic signed [KEY_W-1:0]    ekey;       // entry being carried
		logic [HANDLE_W-1:0]        ehnd;
		logic [HANDLE_W-1:0]        rhnd;       // handle of found entry
	} tok_t;

endpackage

`default_nettype wire

[design/sfi_cell.sv]
// One slot of the sorted table: holds a key and its handle, compares the
// passing token against them and inserts or displaces. Uses sfi_pkg.
`default_nettype none

module sfi_cell #(
	parameter int CNT_W = 7
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     adv,
	input  wire  sfi_pkg::tok_t     tok_in,
	input  wire  [CNT_W-1:0]        cnt_in,
	output sfi_pkg::tok_t           tok_out,
	output logic [CNT_W-1:0]        cnt_out
);
	import sfi_pkg::*;

	tok_t                       tok_q;
	tok_t                       tok_nxt;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0]        hnd_q;
	logic                       vld;
	logic                       wr;

	// slot holds a live entry while slots remain below the entry count
	assign vld = (cnt_in != '0);

	always_comb begin
		tok_nxt = tok_in;
		wr      = 1'b0;
		if (tok_in.act && tok_in.has_entry) begin
			if (vld && key_q == tok_in.ekey) begin
				tok_nxt.has_entry = 1'b0;
				tok_nxt.hit       = 1'b1;
				tok_nxt.rhnd      = hnd_q;
			end else if ((!vld || tok_in.ekey < key_q) && !tok_in.nins) begin
				wr                = 1'b1;
				tok_nxt.has_entry = vld;
				tok_nxt.ekey      = key_q;
				tok_nxt.ehnd      = hnd_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_q <= vld ? cnt_in - CNT_W'(1) : '0;
			if (wr) begin
				key_q <= tok_in.ekey;
				hnd_q <= tok_in.ehnd;
			end
		end
	end

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;

endmodule

`default_nettype wire

[design/sorted_key_find_or_insert.sv]
// A result is registered when the token leaves the end of the cell chain.
// One transaction at a time: the token walks the whole cell chain, one cell per
// cycle unless the chain is stalled, before the next key is taken.
// A stalled result holds the chain only when the next token reaches its end.
// Reset: asynchronous, clears the entry count and all control, not the table.
// Top level: chain of sfi_cell slots plus input and result registers. Uses sfi_pkg.
`default_nettype none

module sorted_key_find_or_insert #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  signed [sfi_pkg::KEY_W-1:0] bin_key,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [sfi_pkg::HANDLE_W-1:0]    handle,
	output logic                            created,
	output logic                            table_full
);
	import sfi_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	tok_t                   tok [TABLE_DEPTH+1];
	logic [CNT_W-1:0]       cnt [TABLE_DEPTH+1];
	tok_t                   tok0_q;
	logic [CNT_W-1:0]       cnt0_q;
	logic [CNT_W-1:0]       count_q;
	logic                   busy_q;
	logic                   out_valid_q;
	logic [HANDLE_W-1:0]    handle_q;
	logic                   created_q;
	logic                   full_q;
	logic                   adv;
	logic                   accept;
	logic                   done;
	tok_t                   tend;

	assign tend     = tok[TABLE_DEPTH];
	assign adv      = !(tend.act && out_valid_q && !out_ready);
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign done     = adv && tend.act;

	assign tok[0] = tok0_q;
	assign cnt[0] = cnt0_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		sfi_cell #(
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok[i]),
			.cnt_in  (cnt[i]),
			.tok_out (tok[i+1]),
			.cnt_out (cnt[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q      <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				tok0_q.act       <= 1'b1;
				tok0_q.has_entry <= 1'b1;
				tok0_q.nins      <= (count_q >= CNT_W'(TABLE_DEPTH));
				tok0_q.hit       <= 1'b0;
				tok0_q.ekey      <= bin_key;
				tok0_q.ehnd      <= HANDLE_W'(count_q);
				tok0_q.rhnd      <= '0;
			end else if (adv) begin
				tok0_q.act <= 1'b0;
			end

			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			if (done) begin
				out_valid_q <= 1'b1;
				if (!tend.hit && !tend.nins) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt0_q <= count_q;
		end
		if (done) begin
			handle_q  <= tend.hit ? tend.rhnd : (tend.nins ? '0 : HANDLE_W'(count_q));
			created_q <= !tend.hit && !tend.nins;
			full_q    <= !tend.hit && tend.nins;
		end
	end

	assign out_valid  = out_valid_q;
	assign handle     = handle_q;
	assign created    = created_q;
	assign table_full = full_q;

`ifndef ASSERT_OFF
	a_idle_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !tend.act)
		else $error("token at chain end while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(created_q && full_q))
		else $error("result both created and full");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && !tend.hit && !tend.nins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("entry count not advanced on insertion");
`endif

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for sorted_key_find_or_insert: drives signed bin keys,
// predicts handle, created and table_full from its own copy of the sorted table.
// Depends on design/sfi_pkg.sv and design/sorted_key_find_or_insert.sv.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfi_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 1) + 16;
	localparam int N_DIRECTED   = 15;
	localparam logic signed [KEY_W-1:0] DIRECTED_KEYS [N_DIRECTED] = '{
		0, -32768, 32767, -1, 1, 0, -32768, 32767, 21845, -21846, 100, -100, 99, -1, 21845
	};
	localparam logic signed [KEY_W-1:0] EDGE_KEYS [4] = '{-32768, 32767, 0, -1};

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic                created;
		logic                table_full;
	} lookup_result_t;

	class bin_table_tracker;
		logic signed [KEY_W-1:0] keys [TABLE_DEPTH];
		logic [HANDLE_W-1:0]     handles [TABLE_DEPTH];
		int                      count;
		lookup_result_t          expected_lookups [$];
		int                      mismatch_count;

		function new();
			count = 0;
			mismatch_count = 0;
		endfunction

		function void note_key(logic signed [KEY_W-1:0] k);
			int pos;
			int i;
			lookup_result_t r;
			pos = 0;
			while (pos < count && keys[pos] < k)
				pos++;
			if (pos < count && keys[pos] == k) begin
				r = '{handle: handles[pos], created: 1'b0, table_full: 1'b0};
			end else if (count >= TABLE_DEPTH) begin
				r = '{handle: HANDLE_W'(0), created: 1'b0, table_full: 1'b1};
			end else begin
				for (i = count; i > pos; i--) begin
					keys[i] = keys[i-1];
					handles[i] = handles[i-1];
				end
				keys[pos] = k;
				handles[pos] = HANDLE_W'(count);
				r = '{handle: HANDLE_W'(count), created: 1'b1, table_full: 1'b0};
				count++;
			end
			expected_lookups.push_back(r);
		endfunction

		function void check_result(lookup_result_t got);
			lookup_result_t want;
			if (expected_lookups.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing pending: handle=%0d created=%0b full=%0b",
						$realtime, got.handle, got.created, got.table_full);
				return;
			end
			want = expected_lookups.pop_front();
			if (got.handle !== want.handle || got.created !== want.created ||
			    got.table_full !== want.table_full) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"%0t: expected handle=%0d created=%0b full=%0b, ",
						"got handle=%0d created=%0b full=%0b"},
						$realtime, want.handle, want.created, want.table_full,
						got.handle, got.created, got.table_full);
			end
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction

		function int entries();
			return count;
		endfunction

		function logic signed [KEY_W-1:0] key_at(int i);
			return keys[i];
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [KEY_W-1:0] bin_key = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [HANDLE_W-1:0]     handle;
	logic                    created;
	logic                    table_full;

	int send_idle_pct = 0;
	int sink_stall_pct = 0;

	bin_table_tracker tracker = new();

	sorted_key_find_or_insert #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.bin_key(bin_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.handle(handle),
		.created(created),
		.table_full(table_full)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready === 1'b1)
			tracker.check_result('{handle: handle, created: created, table_full: table_full});
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task send_key(input logic signed [KEY_W-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		bin_key <= k;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		tracker.note_key(k);
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// hits on stored keys, near misses either side, edge keys, and wide random keys
	function logic signed [KEY_W-1:0] pick_key();
		int roll;
		int n;
		roll = $urandom_range(99);
		n = tracker.entries();
		if (n > 0 && roll < 35)
			return tracker.key_at($urandom_range(n - 1));
		if (n > 0 && roll < 55)
			return KEY_W'(tracker.key_at($urandom_range(n - 1)) +
				($urandom_range(1) ? 1 : -1));
		if (roll < 65)
			return EDGE_KEYS[$urandom_range(3)];
		return KEY_W'($urandom);
	endfunction

	task run_phase(input int items, input int idle_pct, input int stall_pct);
		int i;
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (i = 0; i < items; i++)
			send_key(pick_key());
		wait_drained();
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < N_DIRECTED; i++)
			send_key(DIRECTED_KEYS[i]);
		wait_drained();
		run_phase(170, 0, 0);
		run_phase(170, 50, 0);
		run_phase(170, 0, 50);
		run_phase(170, 29, 29);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
